/* hw/rtl/clock_synth_divider_setup_unit_macros.svh */
// ---------------------------------------------------------------------------
// Clock synth divider setup unit assertion macros
// Concurrent assertion wrappers; empty bodies when building for synthesis.
// ---------------------------------------------------------------------------
`ifndef CLOCK_SYNTH_DIVIDER_SETUP_UNIT_MACROS_SVH
`define CLOCK_SYNTH_DIVIDER_SETUP_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define CSSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CSSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CSSU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define CSSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hw/rtl/cssu_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Clock synth divider setup package
// Types, register map and constants shared by the setup unit modules.
// ---------------------------------------------------------------------------
package cssu_pkg;

    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int FREQ_W    = 27;
    localparam int A_W       = 17;
    localparam int NORM_W    = 20;
    localparam int Q_W       = 8;
    localparam int P_W       = 24;
    localparam int STEP_W    = 4;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [DIV_W-1:0] FREQ_MIN   = 32'd500000;
    localparam logic [DIV_W-1:0] FREQ_MAX   = 32'd109000000;
    localparam logic [P_W-1:0]   P1_OFFSET  = 24'd512;

    localparam logic [7:0] REG_OE_MASK    = 8'd3;
    localparam logic [7:0] REG_CLK_CTRL   = 8'd16;
    localparam logic [7:0] REG_PLLA_BASE  = 8'd26;
    localparam logic [7:0] REG_MS_BASE    = 8'd42;
    localparam logic [7:0] REG_SSC        = 8'd149;
    localparam logic [7:0] REG_PLL_RESET  = 8'd177;
    localparam logic [7:0] REG_XTAL_LOAD  = 8'd183;

    localparam logic [7:0] CLK_CTRL_BASE  = 8'h0C;
    localparam logic [7:0] PLL_RESET_VAL  = 8'h20;
    localparam logic [5:0] XTAL_RSVD      = 6'h12;
    localparam logic [1:0] DRIVE_DEFAULT  = 2'd3;

    localparam logic [STEP_W-1:0] STEP_INIT_SSC       = 4'd0;
    localparam logic [STEP_W-1:0] STEP_INIT_MASK      = 4'd1;
    localparam logic [STEP_W-1:0] STEP_INIT_XTAL      = 4'd2;
    localparam logic [STEP_W-1:0] STEP_INIT_BLK       = 4'd3;
    localparam logic [STEP_W-1:0] STEP_INIT_PLL_RESET = 4'd11;
    localparam logic [STEP_W-1:0] STEP_FREQ_DRIVE     = 4'd8;
    localparam logic [STEP_W-1:0] STEP_FREQ_MASK      = 4'd9;
    localparam logic [2:0]        BLK_LAST            = 3'd7;

    typedef enum logic [2:0] {
        CFG_VCO_FREQ   = 3'd0,
        CFG_OUT_RDIV   = 3'd1,
        CFG_DRIVE_CLK0 = 3'd2,
        CFG_DRIVE_CLK1 = 3'd3,
        CFG_DRIVE_CLK2 = 3'd4,
        CFG_PLL_MULT   = 3'd5,
        CFG_XTAL_LOAD  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] vco_freq;
        logic [2:0]  out_rdiv;
        logic [1:0]  drive_clk0;
        logic [1:0]  drive_clk1;
        logic [1:0]  drive_clk2;
        logic [6:0]  pll_mult;
        logic [1:0]  xtal_load;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV_A,
        S_NORM,
        S_DIV_Q,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        MODE_INIT,
        MODE_FREQ,
        MODE_MASK
    } t_mode;

    typedef struct packed {
        logic              load;
        logic              mask_upd;
        logic              div_a;
        logic              take_a;
        logic              norm;
        logic              div_q;
        logic              take_q;
        logic              out_load;
        logic [STEP_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic func;
        logic sel_ok;
        logic in_range;
        logic norm_done;
        logic div_done;
        logic last;
        logic out_free;
    } t_dp_status;

endpackage

/* hw/rtl/cssu_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Clock synth divider setup channels
// Command channel and register-write result channel, valid/ready.
// ---------------------------------------------------------------------------
interface cssu_cmd_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] fout;
    logic [1:0]  clk_sel;

    modport source (output valid, output func, output fout, output clk_sel, input ready);
    modport sink   (input valid, input func, input fout, input clk_sel, output ready);
endinterface

interface cssu_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
    logic       xfer_end;
    logic       last;

    modport source (output valid, output reg_addr, output reg_data, output xfer_end,
                    output last, input ready);
    modport sink   (input valid, input reg_addr, input reg_data, input xfer_end,
                    input last, output ready);
endinterface

/* hw/rtl/cssu_divider.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module cssu_divider
    import cssu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient,
    output logic [DIV_W-1:0] o_remainder
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_dvs;
    logic [DIV_W:0]       w_shift;
    logic [DIV_W:0]       w_diff;
    logic                 w_ge;

    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = !w_diff[DIV_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_shift[DIV_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

/* hw/rtl/cssu_datapath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Divider setup datapath
// Command capture, divider words, enable mask and result byte register.
// ---------------------------------------------------------------------------
module cssu_datapath
    import cssu_pkg::*;
#(
    parameter int NUM_CLOCKS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_func,
    input  logic [31:0] i_fout,
    input  logic [1:0]  i_clk_sel,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    cssu_res_if.source  o_res
);

    logic              r_func;
    logic [31:0]       r_fout;
    logic [1:0]        r_sel;
    logic [A_W-1:0]    r_a;
    logic [FREQ_W-1:0] r_b;
    logic [FREQ_W-1:0] r_c;
    logic [Q_W-1:0]    r_q;
    logic [NORM_W-1:0] r_p2;
    logic [7:0]        r_mask;
    logic              r_out_valid;
    logic [7:0]        r_out_addr;
    logic [7:0]        r_out_data;
    logic              r_out_end;
    logic              r_out_last;

    logic              w_div_done;
    logic [DIV_W-1:0]  w_quo;
    logic [DIV_W-1:0]  w_rem;
    logic [DIV_W-1:0]  w_dividend;
    logic [DIV_W-1:0]  w_divisor;
    logic              w_sel_ok;
    logic              w_in_range;
    logic [7:0]        w_sel_bit;
    t_mode             w_mode;
    logic [P_W-1:0]    w_init_p1;
    logic [P_W-1:0]    w_set_p1;
    logic [7:0]        w_blk [8];
    logic [2:0]        w_k;
    logic [7:0]        w_blk_base;
    logic [1:0]        w_drive;
    logic [7:0]        w_gen_addr;
    logic [7:0]        w_gen_data;
    logic              w_gen_end;
    logic              w_gen_last;

    assign w_sel_ok   = int'(r_sel) < NUM_CLOCKS;
    assign w_in_range = (r_fout >= FREQ_MIN) && (r_fout <= FREQ_MAX);
    assign w_sel_bit  = 8'(1) << r_sel;

    assign w_dividend = i_cmd.div_q ? DIV_W'({r_b[NORM_W-1:0], 7'b0}) : i_cfg.vco_freq;
    assign w_divisor  = i_cmd.div_q ? DIV_W'(r_c) : r_fout;

    cssu_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_a || i_cmd.div_q),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_fout <= i_fout;
            r_sel  <= i_clk_sel;
        end
        if (i_cmd.take_a) begin
            r_a <= A_W'(w_quo);
            r_b <= FREQ_W'(w_rem);
            r_c <= FREQ_W'(r_fout);
        end else if (i_cmd.norm) begin
            r_b <= r_b >> 1;
            r_c <= r_c >> 1;
        end
        if (i_cmd.take_q) begin
            r_q  <= Q_W'(w_quo);
            r_p2 <= NORM_W'(w_rem);
        end
        if (i_cmd.out_load) begin
            r_out_addr <= w_gen_addr;
            r_out_data <= w_gen_data;
            r_out_end  <= w_gen_end;
            r_out_last <= w_gen_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= 8'hFF;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.mask_upd && r_func && w_sel_ok) begin
                r_mask <= w_in_range ? (r_mask & ~w_sel_bit) : (r_mask | w_sel_bit);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        if (!r_func) begin
            w_mode = MODE_INIT;
        end else if (w_sel_ok && w_in_range) begin
            w_mode = MODE_FREQ;
        end else begin
            w_mode = MODE_MASK;
        end
    end

    assign w_init_p1 = P_W'({i_cfg.pll_mult, 7'b0}) - P1_OFFSET;
    assign w_set_p1  = ({r_a, 7'b0} + P_W'(r_q) - P1_OFFSET) | {1'b0, i_cfg.out_rdiv, 20'b0};

    always_comb begin
        if (w_mode == MODE_INIT) begin
            w_blk[0] = 8'd0;
            w_blk[1] = 8'd1;
            w_blk[2] = w_init_p1[23:16];
            w_blk[3] = w_init_p1[15:8];
            w_blk[4] = w_init_p1[7:0];
            w_blk[5] = 8'd0;
            w_blk[6] = 8'd0;
            w_blk[7] = 8'd0;
            w_k        = 3'(i_cmd.idx - STEP_INIT_BLK);
            w_blk_base = REG_PLLA_BASE;
        end else begin
            w_blk[0] = r_c[15:8];
            w_blk[1] = r_c[7:0];
            w_blk[2] = w_set_p1[23:16];
            w_blk[3] = w_set_p1[15:8];
            w_blk[4] = w_set_p1[7:0];
            w_blk[5] = {r_c[19:16], r_p2[19:16]};
            w_blk[6] = r_p2[15:8];
            w_blk[7] = r_p2[7:0];
            w_k        = i_cmd.idx[2:0];
            w_blk_base = REG_MS_BASE + {3'b0, r_sel, 3'b0};
        end
    end

    always_comb begin
        unique case (r_sel)
            2'd0:    w_drive = i_cfg.drive_clk0;
            2'd1:    w_drive = i_cfg.drive_clk1;
            2'd2:    w_drive = i_cfg.drive_clk2;
            default: w_drive = DRIVE_DEFAULT;
        endcase
    end

    always_comb begin
        w_gen_addr = w_blk_base + {5'b0, w_k};
        w_gen_data = w_blk[w_k];
        w_gen_end  = (w_k == BLK_LAST);
        w_gen_last = 1'b0;
        unique case (w_mode)
            MODE_INIT: begin
                priority if (i_cmd.idx == STEP_INIT_SSC) begin
                    w_gen_addr = REG_SSC;
                    w_gen_data = 8'd0;
                    w_gen_end  = 1'b1;
                end else if (i_cmd.idx == STEP_INIT_MASK) begin
                    w_gen_addr = REG_OE_MASK;
                    w_gen_data = r_mask;
                    w_gen_end  = 1'b1;
                end else if (i_cmd.idx == STEP_INIT_XTAL) begin
                    w_gen_addr = REG_XTAL_LOAD;
                    w_gen_data = {i_cfg.xtal_load, XTAL_RSVD};
                    w_gen_end  = 1'b1;
                end else if (i_cmd.idx == STEP_INIT_PLL_RESET) begin
                    w_gen_addr = REG_PLL_RESET;
                    w_gen_data = PLL_RESET_VAL;
                    w_gen_end  = 1'b1;
                    w_gen_last = 1'b1;
                end else begin
                    // hold the block byte
                end
            end
            MODE_FREQ: begin
                priority if (i_cmd.idx == STEP_FREQ_DRIVE) begin
                    w_gen_addr = REG_CLK_CTRL + {6'b0, r_sel};
                    w_gen_data = CLK_CTRL_BASE | {6'b0, w_drive};
                    w_gen_end  = 1'b1;
                end else if (i_cmd.idx == STEP_FREQ_MASK) begin
                    w_gen_addr = REG_OE_MASK;
                    w_gen_data = r_mask;
                    w_gen_end  = 1'b1;
                    w_gen_last = 1'b1;
                end else begin
                    // hold the block byte
                end
            end
            default: begin
                w_gen_addr = REG_OE_MASK;
                w_gen_data = r_mask;
                w_gen_end  = 1'b1;
                w_gen_last = 1'b1;
            end
        endcase
    end

    assign o_status.func      = r_func;
    assign o_status.sel_ok    = w_sel_ok;
    assign o_status.in_range  = w_in_range;
    assign o_status.norm_done = (r_c[FREQ_W-1:NORM_W] == '0);
    assign o_status.div_done  = w_div_done;
    assign o_status.last      = w_gen_last;
    assign o_status.out_free  = !r_out_valid || o_res.ready;

    assign o_res.valid    = r_out_valid;
    assign o_res.reg_addr = r_out_addr;
    assign o_res.reg_data = r_out_data;
    assign o_res.xfer_end = r_out_end;
    assign o_res.last     = r_out_last;

endmodule

/* hw/rtl/cssu_cfg_regs.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Configuration registers
// APB register file for VCO, divider, drive and init settings.
// ---------------------------------------------------------------------------
module cssu_cfg_regs
    import cssu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_cfg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_cfg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vco_freq   <= 32'd875000000;
            r_cfg.out_rdiv   <= 3'd0;
            r_cfg.drive_clk0 <= 2'd3;
            r_cfg.drive_clk1 <= 2'd3;
            r_cfg.drive_clk2 <= 2'd3;
            r_cfg.pll_mult   <= 7'd35;
            r_cfg.xtal_load  <= 2'd2;
        end else if (w_wr) begin
            unique case (w_idx)
                CFG_VCO_FREQ:   r_cfg.vco_freq   <= pwdata;
                CFG_OUT_RDIV:   r_cfg.out_rdiv   <= pwdata[2:0];
                CFG_DRIVE_CLK0: r_cfg.drive_clk0 <= pwdata[1:0];
                CFG_DRIVE_CLK1: r_cfg.drive_clk1 <= pwdata[1:0];
                CFG_DRIVE_CLK2: r_cfg.drive_clk2 <= pwdata[1:0];
                CFG_PLL_MULT:   r_cfg.pll_mult   <= pwdata[6:0];
                CFG_XTAL_LOAD:  r_cfg.xtal_load  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            CFG_VCO_FREQ:   prdata = r_cfg.vco_freq;
            CFG_OUT_RDIV:   prdata = APB_DATA_W'(r_cfg.out_rdiv);
            CFG_DRIVE_CLK0: prdata = APB_DATA_W'(r_cfg.drive_clk0);
            CFG_DRIVE_CLK1: prdata = APB_DATA_W'(r_cfg.drive_clk1);
            CFG_DRIVE_CLK2: prdata = APB_DATA_W'(r_cfg.drive_clk2);
            CFG_PLL_MULT:   prdata = APB_DATA_W'(r_cfg.pll_mult);
            CFG_XTAL_LOAD:  prdata = APB_DATA_W'(r_cfg.xtal_load);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/cssu_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Divider setup controller
// Sequences command decode, both divisions, normalization and byte output.
// ---------------------------------------------------------------------------
module cssu_ctrl
    import cssu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    output logic       o_cmd_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_idx;
    logic [STEP_W-1:0] n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        o_cmd       = '0;
        o_cmd.idx   = r_idx;
        o_cmd_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.mask_upd = 1'b1;
                n_idx          = '0;
                if (i_status.func && i_status.sel_ok && i_status.in_range) begin
                    o_cmd.div_a = 1'b1;
                    n_state     = S_DIV_A;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_DIV_A: begin
                if (i_status.div_done) begin
                    o_cmd.take_a = 1'b1;
                    n_state      = S_NORM;
                end
            end
            S_NORM: begin
                if (i_status.norm_done) begin
                    o_cmd.div_q = 1'b1;
                    n_state     = S_DIV_Q;
                end else begin
                    o_cmd.norm = 1'b1;
                end
            end
            S_DIV_Q: begin
                if (i_status.div_done) begin
                    o_cmd.take_q = 1'b1;
                    n_state      = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_status.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + STEP_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/clock_synth_divider_setup_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Clock synth divider setup unit
// Turns init and set-frequency commands into clock generator register
// writes. One command is processed at a time. A set-frequency command in
// range makes two passes of the 32-step shared divider (integer part,
// then fractional quotient), up to seven right shifts to fit the
// denominator into 20 bits, and ten result transactions at one per cycle
// while the result channel is ready. Init issues its twelve writes; an
// out-of-range frequency or output issues its single mask write. Result
// backpressure stalls the output. Configuration sits on an APB port,
// register i at byte address 4*i.
// ---------------------------------------------------------------------------
`include "clock_synth_divider_setup_unit_macros.svh"

module clock_synth_divider_setup_unit
    import cssu_pkg::*;
#(
    parameter int NUM_CLOCKS = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    cssu_cmd_if.sink              i_cmd,
    cssu_res_if.source            o_res
);

    t_cfg       w_cfg;
    t_dp_cmd    w_dp_cmd;
    t_dp_status w_dp_status;
    logic       w_cmd_ready;

    cssu_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    cssu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (w_cmd_ready),
        .i_status    (w_dp_status),
        .o_cmd       (w_dp_cmd)
    );

    cssu_datapath #(
        .NUM_CLOCKS (NUM_CLOCKS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_func    (i_cmd.func),
        .i_fout    (i_cmd.fout),
        .i_clk_sel (i_cmd.clk_sel),
        .i_cmd     (w_dp_cmd),
        .o_status  (w_dp_status),
        .o_res     (o_res)
    );

    assign i_cmd.ready = w_cmd_ready;

    `CSSU_ASSERT_NEXT(a_one_cmd_at_a_time, i_clk, i_rst_n, i_cmd.valid && i_cmd.ready, !i_cmd.ready, "command accepted while busy")
    `CSSU_ASSERT_NOW(a_idle_holds_only_last, i_clk, i_rst_n, i_cmd.ready && o_res.valid, o_res.last, "idle with a non-final result pending")
    `CSSU_ASSERT_NOW(a_last_addr, i_clk, i_rst_n, o_res.valid && o_res.last, o_res.reg_addr == REG_OE_MASK || o_res.reg_addr == REG_PLL_RESET, "final result at unexpected register")

endmodule

/* sim/clock_synth_divider_setup_unit_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Clock synth divider setup unit testbench
// Drives init and set-frequency commands through the command channel and
// compares every register-write transaction on the result channel against
// a scoreboard. The scoreboard predicts the divider words, the output-enable
// mask and the transfer marks. Configuration goes through the APB port
// between phases. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module clock_synth_divider_setup_unit_test;
    import cssu_pkg::*;

    localparam int NUM_CLOCKS    = 3;
    localparam int CFG_SPARE_IDX = 7;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 62;
    localparam logic FUNC_INIT     = 1'b0;
    localparam logic FUNC_SET_FREQ = 1'b1;

    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] data;
        logic       xfer_end;
        logic       last;
    } reg_write_t;

    class divider_scoreboard;
        t_cfg       cfg;
        logic [7:0] disable_mask;
        reg_write_t writes_due[$];
        int         failures;

        function new();
            cfg.vco_freq   = 32'd875000000;
            cfg.out_rdiv   = 3'd0;
            cfg.drive_clk0 = DRIVE_DEFAULT;
            cfg.drive_clk1 = DRIVE_DEFAULT;
            cfg.drive_clk2 = DRIVE_DEFAULT;
            cfg.pll_mult   = 7'd35;
            cfg.xtal_load  = 2'd2;
            disable_mask   = 8'hFF;
            failures       = 0;
        endfunction

        function void set_register(int idx, logic [31:0] value);
            case (idx)
                CFG_VCO_FREQ:   cfg.vco_freq   = value;
                CFG_OUT_RDIV:   cfg.out_rdiv   = value[2:0];
                CFG_DRIVE_CLK0: cfg.drive_clk0 = value[1:0];
                CFG_DRIVE_CLK1: cfg.drive_clk1 = value[1:0];
                CFG_DRIVE_CLK2: cfg.drive_clk2 = value[1:0];
                CFG_PLL_MULT:   cfg.pll_mult   = value[6:0];
                CFG_XTAL_LOAD:  cfg.xtal_load  = value[1:0];
                default: ;
            endcase
        endfunction

        function void push_write(logic [7:0] addr, logic [7:0] data, logic xfer_end,
                                 logic last);
            reg_write_t w;
            w.addr     = addr;
            w.data     = data;
            w.xfer_end = xfer_end;
            w.last     = last;
            writes_due.push_back(w);
        endfunction

        function void note_command(logic func, logic [31:0] fout, logic [1:0] sel);
            logic [31:0] whole, rem, denom, frac, p1, p2;
            logic [7:0]  blk [8];
            logic [7:0]  base;
            logic [1:0]  drive;
            if (func == FUNC_INIT) begin
                p1 = 32'd128 * 32'(cfg.pll_mult) - 32'd512;
                push_write(REG_SSC, 8'd0, 1'b1, 1'b0);
                push_write(REG_OE_MASK, disable_mask, 1'b1, 1'b0);
                push_write(REG_XTAL_LOAD, {cfg.xtal_load, XTAL_RSVD}, 1'b1, 1'b0);
                blk = '{8'd0, 8'd1, p1[23:16], p1[15:8], p1[7:0], 8'd0, 8'd0, 8'd0};
                for (int i = 0; i < 8; i++)
                    push_write(REG_PLLA_BASE + 8'(i), blk[i], i == 7, 1'b0);
                push_write(REG_PLL_RESET, PLL_RESET_VAL, 1'b1, 1'b1);
                return;
            end
            if (sel < NUM_CLOCKS) begin
                if (fout < FREQ_MIN || fout > FREQ_MAX) begin
                    disable_mask[sel] = 1'b1;
                end else begin
                    whole = cfg.vco_freq / fout;
                    rem   = cfg.vco_freq % fout;
                    denom = fout;
                    while (denom[31:20] != 0) begin
                        rem   = rem >> 1;
                        denom = denom >> 1;
                    end
                    frac = (32'd128 * rem) / denom;
                    p1   = (32'd128 * whole + frac - 32'd512) | (32'(cfg.out_rdiv) << 20);
                    p2   = 32'd128 * rem - frac * denom;
                    blk  = '{denom[15:8], denom[7:0], p1[23:16], p1[15:8], p1[7:0],
                             {denom[19:16], p2[19:16]}, p2[15:8], p2[7:0]};
                    base = REG_MS_BASE + {3'b000, sel, 3'b000};
                    for (int i = 0; i < 8; i++)
                        push_write(base + 8'(i), blk[i], i == 7, 1'b0);
                    case (sel)
                        2'd0:    drive = cfg.drive_clk0;
                        2'd1:    drive = cfg.drive_clk1;
                        2'd2:    drive = cfg.drive_clk2;
                        default: drive = DRIVE_DEFAULT;
                    endcase
                    push_write(REG_CLK_CTRL + 8'(sel), CLK_CTRL_BASE | 8'(drive), 1'b1, 1'b0);
                    disable_mask[sel] = 1'b0;
                end
            end
            push_write(REG_OE_MASK, disable_mask, 1'b1, 1'b1);
        endfunction

        function void check_result(reg_write_t got);
            reg_write_t want;
            if (writes_due.size() == 0) begin
                failures++;
                $display("%0t: unexpected write addr=%0d data=0x%h xfer_end=%b last=%b",
                         $time, got.addr, got.data, got.xfer_end, got.last);
                return;
            end
            want = writes_due.pop_front();
            if (got.addr !== want.addr || got.data !== want.data ||
                got.xfer_end !== want.xfer_end || got.last !== want.last) begin
                failures++;
                $display("%0t: expected a=%0d d=%h e=%b l=%b, got a=%0d d=%h e=%b l=%b",
                         $time, want.addr, want.data, want.xfer_end, want.last,
                         got.addr, got.data, got.xfer_end, got.last);
            end
        endfunction

        function int pending();
            return writes_due.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    cssu_cmd_if cmd_ch ();
    cssu_res_if res_ch ();

    divider_scoreboard board = new();
    int burst_left = 0;

    clock_synth_divider_setup_unit #(
        .NUM_CLOCKS(NUM_CLOCKS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    always #6 i_clk = ~i_clk;

    task automatic write_reg(input int idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_register(idx, value);
    endtask

    task automatic write_config(input logic [31:0] vco, input logic [2:0] rdiv,
                                input logic [1:0] d0, input logic [1:0] d1,
                                input logic [1:0] d2, input logic [6:0] mult,
                                input logic [1:0] xtal);
        write_reg(CFG_VCO_FREQ, vco);
        write_reg(CFG_OUT_RDIV, {$urandom} & ~32'h7 | 32'(rdiv));
        write_reg(CFG_DRIVE_CLK0, {$urandom} & ~32'h3 | 32'(d0));
        write_reg(CFG_DRIVE_CLK1, 32'(d1));
        write_reg(CFG_DRIVE_CLK2, 32'(d2));
        write_reg(CFG_PLL_MULT, {$urandom} & ~32'h7F | 32'(mult));
        write_reg(CFG_XTAL_LOAD, 32'(xtal));
        if ($urandom_range(0, 1) == 0)
            write_reg(CFG_SPARE_IDX, $urandom);
    endtask

    task automatic send_command(input logic func, input logic [31:0] fout,
                                input logic [1:0] sel);
        cmd_ch.valid   <= 1'b1;
        cmd_ch.func    <= func;
        cmd_ch.fout    <= fout;
        cmd_ch.clk_sel <= sel;
        do @(posedge i_clk); while (!cmd_ch.ready);
        board.note_command(func, fout, sel);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_random_item();
        logic [31:0] fout;
        logic [1:0]  sel;
        int          pick;
        pick = $urandom_range(0, 99);
        sel  = 2'($urandom_range(0, NUM_CLOCKS - 1));
        case ($urandom_range(0, 5))
            0:       fout = $urandom_range(FREQ_MIN, FREQ_MIN + 2000);
            1:       fout = $urandom_range(FREQ_MAX - 2000, FREQ_MAX);
            2:       fout = $urandom_range(FREQ_MIN, 32'h000FFFFF);
            default: fout = $urandom_range(FREQ_MIN, FREQ_MAX);
        endcase
        if (pick < 10) begin
            send_command(FUNC_INIT, $urandom, 2'($urandom_range(0, 3)));
        end else if (pick < 20) begin
            fout = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, FREQ_MIN - 1);
            if (fout >= FREQ_MIN && fout <= FREQ_MAX)
                fout = FREQ_MAX + 1;
            send_command(FUNC_SET_FREQ, fout, sel);
        end else if (pick < 28) begin
            send_command(FUNC_SET_FREQ, $urandom, 2'd3);
        end else begin
            send_command(FUNC_SET_FREQ, fout, sel);
        end
    endtask

    initial begin : result_sink
        reg_write_t got;
        int         seen, mode, mode_left, stall_left, hold_left;
        logic       held;
        seen       = 0;
        mode       = 0;
        mode_left  = 0;
        stall_left = 0;
        hold_left  = 0;
        held       = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                got.addr     = res_ch.reg_addr;
                got.data     = res_ch.reg_data;
                got.xfer_end = res_ch.xfer_end;
                got.last     = res_ch.last;
                board.check_result(got);
                seen++;
            end
            if (!held && seen >= 700) begin
                held      = 1'b1;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= 1'($urandom_range(0, 1));
                    2: res_ch.ready <= ($urandom_range(0, 7) != 0);
                    default: begin
                        if (stall_left > 0) begin
                            stall_left--;
                            res_ch.ready <= 1'b0;
                        end else begin
                            res_ch.ready <= 1'b1;
                            if ($urandom_range(0, 3) == 0)
                                stall_left = $urandom_range(1, 8);
                        end
                    end
                endcase
            end
        end
    end

    initial begin
        #10_000_000;
        $display("clock_synth_divider_setup_unit: mismatch");
        $finish;
    end

    initial begin
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.func    <= FUNC_INIT;
        cmd_ch.fout    <= '0;
        cmd_ch.clk_sel <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        send_command(FUNC_INIT, 32'd0, 2'd0);
        send_command(FUNC_SET_FREQ, 32'd0, 2'd0);
        send_command(FUNC_SET_FREQ, FREQ_MIN - 1, 2'd0);
        send_command(FUNC_SET_FREQ, FREQ_MIN, 2'd0);
        send_command(FUNC_SET_FREQ, FREQ_MAX, 2'd1);
        send_command(FUNC_SET_FREQ, FREQ_MAX + 1, 2'd1);
        send_command(FUNC_SET_FREQ, 32'hFFFFFFFF, 2'd2);
        send_command(FUNC_SET_FREQ, 32'd1000000, 2'd2);
        send_command(FUNC_SET_FREQ, 32'd10000000, 2'd3);
        send_command(FUNC_INIT, 32'hFFFFFFFF, 2'd3);
        wait_idle();

        write_config(32'hFFFFFFFF, 3'd7, 2'd0, 2'd0, 2'd0, 7'd127, 2'd3);
        write_reg(CFG_SPARE_IDX, 32'hFFFFFFFF);
        send_command(FUNC_INIT, 32'd0, 2'd0);
        send_command(FUNC_SET_FREQ, FREQ_MIN, 2'd0);
        send_command(FUNC_SET_FREQ, FREQ_MAX, 2'd1);
        send_command(FUNC_SET_FREQ, 32'd7654321, 2'd2);
        wait_idle();

        write_config(32'd0, 3'd0, 2'd3, 2'd2, 2'd1, 7'd0, 2'd0);
        send_command(FUNC_INIT, 32'd0, 2'd0);
        send_command(FUNC_SET_FREQ, FREQ_MIN, 2'd0);
        send_command(FUNC_SET_FREQ, 32'd12345678, 2'd2);
        send_command(FUNC_SET_FREQ, 32'd0, 2'd3);
        wait_idle();

        write_config(32'd1, 3'd3, 2'd1, 2'd3, 2'd2, 7'd90, 2'd1);
        send_command(FUNC_INIT, 32'd0, 2'd0);
        send_command(FUNC_SET_FREQ, FREQ_MAX, 2'd0);
        send_command(FUNC_SET_FREQ, 32'd3000000, 2'd1);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_VCO_FREQ, $urandom);
                1:       write_reg(CFG_VCO_FREQ, $urandom_range(0, 200000000));
                default: write_reg(CFG_VCO_FREQ, $urandom_range(600000000, 900000000));
            endcase
            write_config(board.cfg.vco_freq, 3'($urandom_range(0, 7)),
                         2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)),
                         7'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                        : $urandom_range(15, 90)),
                         2'($urandom_range(0, 3)));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_random_item();
                if (n == PHASE_ITEMS / 2)
                    wait_idle();
            end
            wait_idle();
        end

        while (board.pending() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (board.failures == 0) begin
            $display("clock_synth_divider_setup_unit: match");
        end else begin
            $display("clock_synth_divider_setup_unit: mismatch");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/cssu_pkg.sv
hw/rtl/cssu_if.sv
hw/rtl/cssu_divider.sv
hw/rtl/cssu_datapath.sv
hw/rtl/cssu_cfg_regs.sv
hw/rtl/cssu_ctrl.sv
hw/rtl/clock_synth_divider_setup_unit.sv
sim/clock_synth_divider_setup_unit_test.sv
